/* rtl/pm_pkg.sv */
// Shared constants and types for the polynomial multiply core.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pm_pkg;

   localparam int MAX_TERMS  = 32;
   localparam int COEFF_BITS = 16;

   // Fixed field widths of the transaction payloads
   localparam int COEFF_W   = 16;
   localparam int PRODUCT_W = 37;
   localparam int DEGREE_W  = 6;

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam int LEN_W = $clog2(2 * MAX_TERMS - 1);
   localparam int MUL_W = 2 * COEFF_BITS;
   localparam int SUM_W = MUL_W + $clog2(MAX_TERMS);

   localparam logic SEL_FIRST  = 1'b0;
   localparam logic SEL_SECOND = 1'b1;

   typedef struct packed {
      logic advance;
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic             first_en;
      logic             second_en;
      logic [IDX_W-1:0] idx;
   } load_ctrl_type;

endpackage

`default_nettype wire

/* rtl/pm_req_if.sv */
// Request channel: operand coefficient transactions.
// Depends on pm_pkg for field widths.
`default_nettype none

interface pm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [pm_pkg::COEFF_W-1:0] coeff_value;
   logic                        last;

   modport source (output valid, output req_type, output coeff_value, output last,
                    input ready);
   modport sink   (input valid, input req_type, input coeff_value, input last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/pm_rsp_if.sv */
// Response channel: product coefficient transactions.
// Depends on pm_pkg for field widths.
`default_nettype none

interface pm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [pm_pkg::PRODUCT_W-1:0] product_coeff;
   logic [pm_pkg::DEGREE_W-1:0]   degree_index;
   logic                          last_result;

   modport source (output valid, output product_coeff, output degree_index,
                    output last_result, input ready);
   modport sink   (input valid, input product_coeff, input degree_index,
                    input last_result, output ready);
endinterface

`default_nettype wire

/* rtl/polynomial_multiply_core.sv */
// Polynomial multiply core: top level joining the sequencer and the cell chain.
// Depends on pm_pkg, pm_req_if, pm_rsp_if, pm_ctrl and pm_cell.
`default_nettype none

// Multiplies two polynomials by full convolution. Each request transaction
// loads one coefficient (signed Q8.8, lowest degree first) of the first or
// second operand. The second operand's last-marked transaction starts a run
// of na+nb-1 product coefficients (signed Q21.16, exact), lowest degree
// first, the final one marked; an empty first operand gives all-zero
// products. While the response is not stalled, the second operand streams
// one coefficient per cycle past a chain of MAX_TERMS cells, each doing one
// multiply and one add per cycle, and the result emerges from cell 0. No
// requests are taken during a run; both operands are empty once the last
// product has been taken.
module polynomial_multiply_core (
   input  wire      clock,
   input  wire      reset,
   pm_req_if.sink   req_chan,
   pm_rsp_if.source rsp_chan
);

   localparam int N = pm_pkg::MAX_TERMS;

   pm_pkg::cell_ctrl_type             cell_ctrl;
   pm_pkg::load_ctrl_type             load_ctrl;
   logic [pm_pkg::CNT_W-1:0]          first_count;
   logic                              x_enable;
   logic                              req_accept;
   logic signed [pm_pkg::COEFF_BITS-1:0] coeff_in;
   logic signed [pm_pkg::COEFF_BITS-1:0] x_bcast;
   logic signed [pm_pkg::COEFF_BITS-1:0] b_chain [N+1];
   logic signed [pm_pkg::SUM_W-1:0]      s_chain [N+1];

   assign req_accept = req_chan.valid && req_chan.ready;
   assign coeff_in   = req_chan.coeff_value[pm_pkg::COEFF_BITS-1:0];
   assign x_bcast    = x_enable ? b_chain[0] : '0;
   assign b_chain[N] = '0;
   assign s_chain[N] = '0;

   pm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_sel     (req_chan.req_type),
      .req_last    (req_chan.last),
      .rsp_ready   (rsp_chan.ready),
      .req_ready   (req_chan.ready),
      .cell_ctrl   (cell_ctrl),
      .load_ctrl   (load_ctrl),
      .first_count (first_count),
      .x_enable    (x_enable),
      .rsp_valid   (rsp_chan.valid),
      .rsp_degree  (rsp_chan.degree_index),
      .rsp_last    (rsp_chan.last_result)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      pm_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .load_first  (load_ctrl.first_en && (load_ctrl.idx == pm_pkg::IDX_W'(i))),
         .load_second (load_ctrl.second_en && (load_ctrl.idx == pm_pkg::IDX_W'(i))),
         .keep        (pm_pkg::CNT_W'(i) < first_count),
         .coeff_in    (coeff_in),
         .x_in        (x_bcast),
         .b_next_in   (b_chain[i+1]),
         .b_out       (b_chain[i]),
         .s_next_in   (s_chain[i+1]),
         .s_out       (s_chain[i])
      );
   end

   assign rsp_chan.product_coeff = pm_pkg::PRODUCT_W'(s_chain[0]);

endmodule

`default_nettype wire

/* rtl/pm_cell.sv */
// One cell of the convolution chain: holds one coefficient of each operand,
// a product register and a partial sum passed toward cell 0. Uses pm_pkg.
`default_nettype none

module pm_cell (
   input  wire                                   clock,
   input  pm_pkg::cell_ctrl_type                 ctrl,
   input  wire                                   load_first,
   input  wire                                   load_second,
   input  wire                                   keep,
   input  wire  signed [pm_pkg::COEFF_BITS-1:0]  coeff_in,
   input  wire  signed [pm_pkg::COEFF_BITS-1:0]  x_in,
   input  wire  signed [pm_pkg::COEFF_BITS-1:0]  b_next_in,
   output logic signed [pm_pkg::COEFF_BITS-1:0]  b_out,
   input  wire  signed [pm_pkg::SUM_W-1:0]       s_next_in,
   output logic signed [pm_pkg::SUM_W-1:0]       s_out
);

   logic signed [pm_pkg::COEFF_BITS-1:0] a_ff, a_in;
   logic signed [pm_pkg::COEFF_BITS-1:0] b_ff, b_in;
   logic signed [pm_pkg::COEFF_BITS-1:0] a_eff;
   logic signed [pm_pkg::MUL_W-1:0]      m_ff, m_in;
   logic signed [pm_pkg::SUM_W-1:0]      s_ff, s_in;

   always_comb begin
      // coefficients past the first operand's count act as zero
      a_eff = keep ? a_ff : '0;
      a_in  = load_first ? coeff_in : a_ff;

      priority if (load_second) begin
         b_in = coeff_in;
      end else if (ctrl.shift) begin
         b_in = b_next_in;
      end else begin
         b_in = b_ff;
      end

      if (ctrl.clear) begin
         m_in = '0;
         s_in = '0;
      end else if (ctrl.advance) begin
         m_in = a_eff * x_in;
         s_in = pm_pkg::SUM_W'(m_ff) + s_next_in;
      end else begin
         m_in = m_ff;
         s_in = s_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      s_ff <= s_in;
   end

   assign b_out = b_ff;
   assign s_out = s_ff;

endmodule

`default_nettype wire

/* rtl/pm_ctrl.sv */
// Sequencer: operand counts, load addressing, run counter and the
// valid/degree pipeline that tracks the cell chain. Uses pm_pkg.
`default_nettype none

module pm_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_accept,
   input  wire                              req_sel,
   input  wire                              req_last,
   input  wire                              rsp_ready,
   output logic                             req_ready,
   output pm_pkg::cell_ctrl_type            cell_ctrl,
   output pm_pkg::load_ctrl_type            load_ctrl,
   output logic [pm_pkg::CNT_W-1:0]         first_count,
   output logic                             x_enable,
   output logic                             rsp_valid,
   output logic [pm_pkg::DEGREE_W-1:0]      rsp_degree,
   output logic                             rsp_last
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_FEED  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam int SUM_LEN_W = pm_pkg::LEN_W + 1;

   logic [1:0]               state_ff, state_in;
   logic [pm_pkg::CNT_W-1:0] first_count_ff, first_count_in;
   logic [pm_pkg::CNT_W-1:0] second_count_ff, second_count_in;
   logic                     first_done_ff, first_done_in;
   logic [pm_pkg::LEN_W-1:0] t_ff, t_in;
   logic [pm_pkg::LEN_W-1:0] last_idx_ff, last_idx_in;
   logic                     v1_ff, v1_in, v2_ff, v2_in;
   logic [pm_pkg::LEN_W-1:0] k1_ff, k1_in, k2_ff, k2_in;
   logic                     l1_ff, l1_in, l2_ff, l2_in;

   logic                     adv;
   logic                     start;
   logic [pm_pkg::CNT_W-1:0] first_base;
   logic [pm_pkg::CNT_W-1:0] second_new;
   logic [pm_pkg::CNT_W-1:0] na;
   logic [SUM_LEN_W-1:0]     len_sum;

   always_comb begin
      adv        = !v2_ff || rsp_ready;
      req_ready  = (state_ff == ST_LOAD);
      start      = req_accept && (req_sel == pm_pkg::SEL_SECOND) && req_last;
      // a first-operand transaction after a completed first operand restarts it
      first_base = first_done_ff ? '0 : first_count_ff;

      load_ctrl.first_en  = req_accept && (req_sel == pm_pkg::SEL_FIRST)
                            && (first_base < pm_pkg::CNT_W'(pm_pkg::MAX_TERMS));
      load_ctrl.second_en = req_accept && (req_sel == pm_pkg::SEL_SECOND)
                            && (second_count_ff < pm_pkg::CNT_W'(pm_pkg::MAX_TERMS));
      load_ctrl.idx = (req_sel == pm_pkg::SEL_FIRST) ? first_base[pm_pkg::IDX_W-1:0]
                                                    : second_count_ff[pm_pkg::IDX_W-1:0];

      second_new = second_count_ff + pm_pkg::CNT_W'(load_ctrl.second_en);
      // an empty first operand counts as one zero coefficient
      na         = (first_count_ff == '0) ? pm_pkg::CNT_W'(1) : first_count_ff;
      len_sum    = SUM_LEN_W'(na) + SUM_LEN_W'(second_new) - SUM_LEN_W'(2);

      cell_ctrl.advance = adv;
      cell_ctrl.clear   = start;
      cell_ctrl.shift   = adv && (state_ff == ST_FEED);

      x_enable = SUM_LEN_W'(t_ff) < SUM_LEN_W'(second_count_ff);
   end

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      first_done_in   = first_done_ff;
      t_in            = t_ff;
      last_idx_in     = last_idx_ff;
      v1_in = v1_ff;
      k1_in = k1_ff;
      l1_in = l1_ff;
      v2_in = v2_ff;
      k2_in = k2_ff;
      l2_in = l2_ff;

      if (adv) begin
         v1_in = (state_ff == ST_FEED);
         k1_in = t_ff;
         l1_in = (t_ff == last_idx_ff);
         v2_in = v1_ff;
         k2_in = k1_ff;
         l2_in = l1_ff;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (req_sel == pm_pkg::SEL_FIRST) begin
                  first_count_in = first_base + pm_pkg::CNT_W'(load_ctrl.first_en);
                  first_done_in  = req_last;
               end else begin
                  second_count_in = second_new;
                  if (req_last) begin
                     state_in    = ST_FEED;
                     t_in        = '0;
                     last_idx_in = len_sum[pm_pkg::LEN_W-1:0];
                     v1_in       = 1'b0;
                     v2_in       = 1'b0;
                  end
               end
            end
         end
         ST_FEED: begin
            if (adv) begin
               t_in = t_ff + pm_pkg::LEN_W'(1);
               if (t_ff == last_idx_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // drop both operands once the final product transaction leaves
            if (v2_ff && rsp_ready && l2_ff) begin
               state_in        = ST_LOAD;
               first_count_in  = '0;
               second_count_in = '0;
               first_done_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_done_ff   <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_done_ff   <= first_done_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
      end
      t_ff        <= t_in;
      last_idx_ff <= last_idx_in;
      k1_ff       <= k1_in;
      l1_ff       <= l1_in;
      k2_ff       <= k2_in;
      l2_ff       <= l2_in;
   end

   assign first_count = first_count_ff;
   assign rsp_valid   = v2_ff;
   assign rsp_degree  = pm_pkg::DEGREE_W'(k2_ff);
   assign rsp_last    = l2_ff;

endmodule

`default_nettype wire

/* rtl/pm_checker.sv */
// Port-level checks for polynomial_multiply_core, attached with bind.
// Depends on pm_pkg and the top level's interface ports.
`default_nettype none

module pm_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          req_type,
   input wire                          req_last,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [pm_pkg::PRODUCT_W-1:0]  rsp_product,
   input wire [pm_pkg::DEGREE_W-1:0]   rsp_degree,
   input wire                          rsp_last
);

   // no request is taken while products are being delivered
   a_busy_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a product is pending");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == pm_pkg::SEL_SECOND) && req_last)
      |=> (!req_ready && !rsp_valid))
      else $error("run did not start after closing second operand");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> !req_ready)
      else $error("requests reopened before the final product");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_product)
                                     && $stable(rsp_degree) && $stable(rsp_last)))
      else $error("stalled product transaction changed");

endmodule

bind polynomial_multiply_core pm_checker u_pm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_type    (req_chan.req_type),
   .req_last    (req_chan.last),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_product (rsp_chan.product_coeff),
   .rsp_degree  (rsp_chan.degree_index),
   .rsp_last    (rsp_chan.last_result)
);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for polynomial_multiply_core: loads operand coefficients,
// predicts every product term of the convolution and checks the response stream.
// Depends on pm_pkg, pm_req_if, pm_rsp_if and the core itself.

module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEM_TARGET    = 200;
   localparam int QUIET_TAIL     = 160;

   typedef struct packed {
      logic signed [pm_pkg::PRODUCT_W-1:0] coeff;
      logic [pm_pkg::DEGREE_W-1:0]         degree;
      logic                                last;
   } product_term_type;

   // Tracks both operand stores and holds the product terms still owed.
   class product_scoreboard_type;
      logic signed [pm_pkg::COEFF_W-1:0] first_coeffs [pm_pkg::MAX_TERMS];
      logic signed [pm_pkg::COEFF_W-1:0] second_coeffs [pm_pkg::MAX_TERMS];
      int               first_count;
      int               second_count;
      bit               first_done;
      product_term_type expected_terms [$];
      int               mismatches;
      int               loads;
      int               bursts;
      int               terms_checked;
      int               dropped_loads;

      function new();
         first_count   = 0;
         second_count  = 0;
         first_done    = 1'b0;
         mismatches    = 0;
         loads         = 0;
         bursts        = 0;
         terms_checked = 0;
         dropped_loads = 0;
      endfunction

      function int outstanding();
         return expected_terms.size();
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] error: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_request(logic sel, logic signed [pm_pkg::COEFF_W-1:0] value,
                                 logic is_last);
         int               na;
         int               nb;
         longint           acc;
         product_term_type term;
         loads++;
         if (sel == pm_pkg::SEL_FIRST) begin
            // a first-operand load after completion starts a fresh operand
            if (first_done) begin
               first_count = 0;
               first_done  = 1'b0;
            end
            if (first_count < pm_pkg::MAX_TERMS) begin
               first_coeffs[pm_pkg::IDX_W'(first_count)] = value;
               first_count++;
            end else begin
               dropped_loads++;
            end
            if (is_last)
               first_done = 1'b1;
            return;
         end
         if (second_count < pm_pkg::MAX_TERMS) begin
            second_coeffs[pm_pkg::IDX_W'(second_count)] = value;
            second_count++;
         end else begin
            dropped_loads++;
         end
         if (!is_last)
            return;
         na = first_count;
         nb = second_count;
         // empty first operand acts as the zero polynomial
         if (na == 0) begin
            first_coeffs[0] = '0;
            na = 1;
         end
         for (int k = 0; k < na + nb - 1; k++) begin
            acc = 0;
            for (int i = 0; i < na; i++) begin
               if (i <= k && k - i < nb)
                  acc += longint'(first_coeffs[pm_pkg::IDX_W'(i)])
                         * longint'(second_coeffs[pm_pkg::IDX_W'(k - i)]);
            end
            term.coeff  = acc[pm_pkg::PRODUCT_W-1:0];
            term.degree = k[pm_pkg::DEGREE_W-1:0];
            term.last   = (k == na + nb - 2);
            expected_terms.push_back(term);
         end
         bursts++;
         first_count  = 0;
         second_count = 0;
         first_done   = 1'b0;
      endfunction

      task check_product(logic signed [pm_pkg::PRODUCT_W-1:0] coeff,
                         logic [pm_pkg::DEGREE_W-1:0] degree, logic last);
         product_term_type want;
         if (expected_terms.size() == 0) begin
            report_mismatch($sformatf("unexpected product term, degree %0d value %0d",
                                      degree, coeff));
            return;
         end
         want = expected_terms.pop_front();
         terms_checked++;
         if (coeff !== want.coeff)
            report_mismatch($sformatf("degree %0d: product_coeff %0d, want %0d",
                                      want.degree, coeff, want.coeff));
         if (degree !== want.degree)
            report_mismatch($sformatf("degree_index %0d, want %0d", degree, want.degree));
         if (last !== want.last)
            report_mismatch($sformatf("degree %0d: last_result %0b, want %0b",
                                      want.degree, last, want.last));
      endtask
   endclass

   logic clock;
   logic reset;

   pm_req_if req_bus ();
   pm_rsp_if rsp_bus ();

   polynomial_multiply_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   product_scoreboard_type sb;

   bit idling_on;
   int long_stall_cycles;
   int hold_count;
   int quiet_cycles;
   int items_sent;
   int choice;
   int len_a;
   int len_b;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function logic signed [pm_pkg::COEFF_W-1:0] random_coeff();
      case ($urandom_range(0, 11))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Mostly short operands, now and then a long one that can overflow the store.
   function int pick_length();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(30, 36);
      return $urandom_range(1, 8);
   endfunction

   task send_coeff(logic sel, logic signed [pm_pkg::COEFF_W-1:0] value, logic is_last);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= sel;
      req_bus.coeff_value <= value;
      req_bus.last        <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task send_operand(logic sel, int count, logic mark_last);
      for (int i = 0; i < count; i++)
         send_coeff(sel, random_coeff(), mark_last && (i == count - 1));
   endtask

   // Stop offering and hold until every owed product term has been taken.
   task drain_products();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      hold_count    = 0;
      forever begin
         @(negedge clock);
         if (long_stall_cycles > 0) begin
            hold_count        = long_stall_cycles;
            long_stall_cycles = 0;
         end else if (hold_count == 0 && idling_on && $urandom_range(0, 7) == 0) begin
            hold_count = $urandom_range(1, 19);
         end
         if (hold_count > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_count--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Sample both channels at the rising edge; count cycles with no transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.req_type, req_bus.coeff_value, req_bus.last);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_product(rsp_bus.product_coeff, rsp_bus.degree_index,
                             rsp_bus.last_result);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      sb                  = new();
      reset               = 1'b1;
      idling_on           = 1'b0;
      long_stall_cycles   = 0;
      quiet_cycles        = 0;
      items_sent          = 0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = pm_pkg::SEL_FIRST;
      req_bus.coeff_value = '0;
      req_bus.last        = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extreme coefficients on both operands
      send_coeff(pm_pkg::SEL_FIRST,  16'sh7FFF, 1'b0);
      send_coeff(pm_pkg::SEL_FIRST,  16'sh8000, 1'b1);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh8000, 1'b0);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh7FFF, 1'b1);
      // empty first operand
      send_coeff(pm_pkg::SEL_SECOND, 16'shFFFF, 1'b0);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh0100, 1'b1);
      // first operand reloaded after it was complete
      send_coeff(pm_pkg::SEL_FIRST,  16'sh0005, 1'b1);
      send_coeff(pm_pkg::SEL_FIRST,  16'sh0200, 1'b0);
      send_coeff(pm_pkg::SEL_FIRST,  16'sh8000, 1'b1);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh7FFF, 1'b1);
      // second operand ends while the first is still open
      send_coeff(pm_pkg::SEL_FIRST,  16'sh0003, 1'b0);
      send_coeff(pm_pkg::SEL_FIRST,  16'shFFFF, 1'b0);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh0002, 1'b1);
      // single zero terms
      send_coeff(pm_pkg::SEL_FIRST,  16'sh0000, 1'b1);
      send_coeff(pm_pkg::SEL_SECOND, 16'sh0000, 1'b1);
      // operands interleaved
      send_coeff(pm_pkg::SEL_FIRST,  16'sh1234, 1'b0);
      send_coeff(pm_pkg::SEL_SECOND, 16'shEDCB, 1'b0);
      send_coeff(pm_pkg::SEL_FIRST,  16'sh5555, 1'b1);
      send_coeff(pm_pkg::SEL_SECOND, 16'shAAAA, 1'b1);
      drain_products();

      // Overfilled stores with the last mark on a dropped item, taken under a long
      // response hold-off while the next operand keeps the input side busy.
      long_stall_cycles = 400;
      send_operand(pm_pkg::SEL_FIRST, 34, 1'b1);
      send_operand(pm_pkg::SEL_SECOND, 33, 1'b1);
      send_operand(pm_pkg::SEL_FIRST, 3, 1'b1);
      send_operand(pm_pkg::SEL_SECOND, 2, 1'b1);
      drain_products();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent < QUIET_TAIL)
            idling_on = ($urandom_range(0, 3) != 0);
         else
            idling_on = 1'b0;
         choice = $urandom_range(0, 9);
         len_a  = pick_length();
         len_b  = pick_length();
         if (choice <= 5) begin
            if ($urandom_range(0, 7) == 0)
               len_a = 0;
            send_operand(pm_pkg::SEL_FIRST, len_a, 1'b1);
            send_operand(pm_pkg::SEL_SECOND, len_b, 1'b1);
         end else if (choice == 6) begin
            // discard a finished first operand by starting another
            send_operand(pm_pkg::SEL_FIRST, $urandom_range(1, 4), 1'b1);
            send_operand(pm_pkg::SEL_FIRST, len_a, 1'b1);
            send_operand(pm_pkg::SEL_SECOND, len_b, 1'b1);
         end else if (choice == 7) begin
            send_operand(pm_pkg::SEL_FIRST, len_a, 1'b0);
            send_operand(pm_pkg::SEL_SECOND, len_b, 1'b1);
         end else if (choice == 8) begin
            for (int i = 0; i < len_a || i < len_b; i++) begin
               if (i < len_a)
                  send_coeff(pm_pkg::SEL_FIRST, random_coeff(), i == len_a - 1);
               if (i < len_b)
                  send_coeff(pm_pkg::SEL_SECOND, random_coeff(), i == len_b - 1);
            end
         end else begin
            send_operand(pm_pkg::SEL_FIRST, len_a, 1'b1);
            send_operand(pm_pkg::SEL_SECOND, len_b, 1'b1);
            drain_products();
         end
      end

      drain_products();
      repeat (80) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report_mismatch($sformatf("%0d product terms never arrived", sb.outstanding()));
      $display("Covered %0d coefficient loads (%0d beyond a full store) and %0d products,",
               sb.loads, sb.dropped_loads, sb.bursts);
      $display("checking %0d terms, with empty, reloaded and open operands and a long stall.",
               sb.terms_checked);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
